// File: src/bae_pkg.sv
package bae_pkg;

  localparam int DEPTH = 16;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  // Comparison width: holds any count, index or capacity plus a small offset.
  localparam int CMPW  = ((CW > 5) ? CW : 5) + 1;
  localparam int DW    = 32;
  localparam int VW    = 36;

  typedef enum logic [3:0] {
    CMD_APPEND  = 4'd0,
    CMD_INSERT  = 4'd1,
    CMD_GET     = 4'd2,
    CMD_EDIT    = 4'd3,
    CMD_DELETE  = 4'd4,
    CMD_SWAP    = 4'd5,
    CMD_SORT    = 4'd6,
    CMD_MAX     = 4'd7,
    CMD_MIN     = 4'd8,
    CMD_SEARCH  = 4'd9,
    CMD_SUM     = 4'd10,
    CMD_ROTATE  = 4'd11,
    CMD_DEDUPE  = 4'd12,
    CMD_SECOND  = 4'd13,
    CMD_STATUS  = 4'd14
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADIDX = 2'd1,
    ST_OVER   = 2'd2,
    ST_EMPTY  = 2'd3
  } st_e;

  typedef enum logic [4:0] {
    S_IDLE, S_EXEC, S_ROT_LD, S_SHUP_RD, S_SHUP_WR, S_PUT, S_SHDN_RD, S_SHDN_WR,
    S_RD_WAIT, S_SWP_WR1, S_SWP_WR2, S_SRT_RD, S_SRT_CMP, S_SRT_WR2, S_SRT_END,
    S_RED_RD, S_RED_AC, S_DD_RD, S_DD_CMP, S_DONE
  } state_e;

  typedef enum logic [1:0] {W_DATA, W_RDA, W_RDB, W_HOLD} wsel_e;
  typedef enum logic [2:0] {A_HOLD, A_CLR, A_LOAD, A_MAX, A_MIN, A_ADD} acc_e;
  typedef enum logic [1:0] {V_ZERO, V_NEG1, V_ACC} vsel_e;

  typedef struct packed {
    logic          lat;
    logic [AW-1:0] raddr_a;
    logic [AW-1:0] raddr_b;
    logic          we;
    logic [AW-1:0] waddr;
    wsel_e         wsel;
    logic          hold_ld;
    logic          cnt_we;
    logic [CW-1:0] cnt_val;
    acc_e          acc_op;
    logic          fnd_clr;
    logic          fnd_set;
    logic          emit;
    st_e           st;
    vsel_e         vsel;
  } ctl_t;

  typedef struct packed {
    logic [CW-1:0] count;
    logic          gt;
    logic          eq;
  } dps_t;

endpackage

// File: src/bae_ram.sv
module bae_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// File: src/bae_dpath.sv
module bae_dpath import bae_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [31:0]   data_in_i,
  input  ctl_t          ctl_i,
  output dps_t          dps_o,
  output logic [35:0]   value_o,
  output logic          found_o,
  output logic [1:0]    status_o,
  output logic [4:0]    fill_count_o,
  output logic          result_valid_o
);

  logic [DW-1:0] rda, rdb, wdata;
  logic [DW-1:0] data_q, hold_q;
  logic [CW-1:0] count_q;
  logic [VW-1:0] acc_q, acc_d, rda_x;
  logic          found_q, valid_q;
  logic [VW-1:0] value_q;
  logic [1:0]    status_q;
  logic [4:0]    fill_q;

  bae_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_ram (
    .clk_i     (clk_i),
    .we_i      (ctl_i.we),
    .waddr_i   (ctl_i.waddr),
    .wdata_i   (wdata),
    .raddr_a_i (ctl_i.raddr_a),
    .raddr_b_i (ctl_i.raddr_b),
    .rdata_a_o (rda),
    .rdata_b_o (rdb)
  );

  always_comb begin
    case (ctl_i.wsel)
      W_DATA:  wdata = data_q;
      W_RDA:   wdata = rda;
      W_RDB:   wdata = rdb;
      W_HOLD:  wdata = hold_q;
      default: wdata = data_q;
    endcase
  end

  assign rda_x = {{(VW-DW){rda[DW-1]}}, rda};

  always_comb begin
    case (ctl_i.acc_op)
      A_CLR:   acc_d = '0;
      A_LOAD:  acc_d = rda_x;
      A_MAX:   acc_d = ($signed(rda_x) > $signed(acc_q)) ? rda_x : acc_q;
      A_MIN:   acc_d = ($signed(rda_x) < $signed(acc_q)) ? rda_x : acc_q;
      A_ADD:   acc_d = acc_q + rda_x;
      default: acc_d = acc_q;
    endcase
  end

  assign dps_o.count = count_q;
  assign dps_o.gt    = $signed(rda) > $signed(rdb);
  assign dps_o.eq    = (rda == rdb);

  always_ff @(posedge clk_i) begin
    if (ctl_i.lat) begin
      data_q <= data_in_i;
    end
    if (ctl_i.hold_ld) begin
      hold_q <= rda;
    end
    acc_q <= acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      found_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      if (ctl_i.cnt_we) begin
        count_q <= ctl_i.cnt_val;
      end
      if (ctl_i.fnd_clr) begin
        found_q <= 1'b0;
      end else if (ctl_i.fnd_set && (rda == data_q)) begin
        found_q <= 1'b1;
      end
      valid_q <= ctl_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit) begin
      case (ctl_i.vsel)
        V_NEG1:  value_q <= '1;
        V_ACC:   value_q <= acc_q;
        default: value_q <= '0;
      endcase
      status_q <= ctl_i.st;
      fill_q   <= 5'(count_q);
    end
  end

  assign value_o        = value_q;
  assign found_o        = found_q;
  assign status_o       = status_q;
  assign fill_count_o   = fill_q;
  assign result_valid_o = valid_q;

endmodule

// File: src/bae_ctrl.sv
module bae_ctrl import bae_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  command_i,
  input  logic [4:0]  index_i,
  input  logic [4:0]  other_index_i,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_data_i,
  input  dps_t        dps_i,
  output ctl_t        ctl_o
);

  state_e        state_q, state_d;
  cmd_e          cmd_q, cmd_d;
  logic [4:0]    idx_q, idx_d, oidx_q, oidx_d, cap_q;
  logic [CW-1:0] i_q, i_d, j_q, j_d, k_q, k_d, lo_q, lo_d;
  st_e           st_q, st_d;
  vsel_e         vsel_q, vsel_d;

  logic [CMPW-1:0] nn, ix, ox, iw, jw, kw, lw;
  logic full, ibad, igt, obad, nz, nlt2, del_more, srt_more, jlt, dd_wr;

  assign nn = CMPW'(dps_i.count);
  assign ix = CMPW'(idx_q);
  assign ox = CMPW'(oidx_q);
  assign iw = CMPW'(i_q);
  assign jw = CMPW'(j_q);
  assign kw = CMPW'(k_q);
  assign lw = CMPW'(lo_q);

  assign full     = (nn >= CMPW'(cap_q)) || (nn >= CMPW'(DEPTH));
  assign ibad     = ix >= nn;
  assign igt      = ix > nn;
  assign obad     = ox >= nn;
  assign nz       = (nn == '0);
  assign nlt2     = nn < CMPW'(2);
  assign del_more = (ix + CMPW'(1)) < nn;
  assign srt_more = ((jw + CMPW'(1)) < nn) || ((iw + CMPW'(2)) < nn);
  assign jlt      = jw < kw;
  assign dd_wr    = !jlt;

  assign busy = (state_q != S_IDLE);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (start) state_d = S_EXEC;
      S_EXEC: begin
        case (cmd_q)
          CMD_INSERT: begin
            if (igt || full) state_d = S_DONE;
            else if (nn > ix) state_d = S_SHUP_RD;
            else state_d = S_PUT;
          end
          CMD_GET:    state_d = ibad ? S_DONE : S_RD_WAIT;
          CMD_DELETE: state_d = (!ibad && del_more) ? S_SHDN_RD : S_DONE;
          CMD_SWAP:   state_d = (ibad || obad) ? S_DONE : S_SWP_WR1;
          CMD_SORT, CMD_SECOND: state_d = nlt2 ? S_SRT_END : S_SRT_RD;
          CMD_MAX, CMD_MIN, CMD_SUM, CMD_SEARCH: state_d = nz ? S_DONE : S_RED_RD;
          CMD_ROTATE: state_d = nz ? S_DONE : S_ROT_LD;
          CMD_DEDUPE: state_d = nz ? S_DONE : S_DD_RD;
          default:    state_d = S_DONE;
        endcase
      end
      S_ROT_LD:  state_d = (nn > CMPW'(1)) ? S_SHUP_RD : S_PUT;
      S_SHUP_RD: state_d = S_SHUP_WR;
      S_SHUP_WR: state_d = ((iw - CMPW'(1)) > lw) ? S_SHUP_RD : S_PUT;
      S_PUT:     state_d = S_DONE;
      S_SHDN_RD: state_d = S_SHDN_WR;
      S_SHDN_WR: state_d = ((iw + CMPW'(2)) < nn) ? S_SHDN_RD : S_DONE;
      S_RD_WAIT: state_d = S_DONE;
      S_SWP_WR1: state_d = S_SWP_WR2;
      S_SWP_WR2: state_d = S_DONE;
      S_SRT_RD:  state_d = S_SRT_CMP;
      S_SRT_CMP: begin
        if (dps_i.gt) state_d = S_SRT_WR2;
        else state_d = srt_more ? S_SRT_RD : S_SRT_END;
      end
      S_SRT_WR2: state_d = srt_more ? S_SRT_RD : S_SRT_END;
      S_SRT_END: state_d = (cmd_q == CMD_SECOND && !nlt2) ? S_RD_WAIT : S_DONE;
      S_RED_RD:  state_d = S_RED_AC;
      S_RED_AC:  state_d = ((iw + CMPW'(1)) < nn) ? S_RED_RD : S_DONE;
      S_DD_RD:   state_d = S_DD_CMP;
      S_DD_CMP: begin
        if (jlt && !dps_i.eq) state_d = S_DD_RD;
        else state_d = ((iw + CMPW'(1)) < nn) ? S_DD_RD : S_DONE;
      end
      S_DONE:    state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // Loop counters and the latched request.
  always_comb begin
    cmd_d  = cmd_q;
    idx_d  = idx_q;
    oidx_d = oidx_q;
    i_d    = i_q;
    j_d    = j_q;
    k_d    = k_q;
    lo_d   = lo_q;
    st_d   = st_q;
    vsel_d = vsel_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_d  = cmd_e'(command_i);
          idx_d  = index_i;
          oidx_d = other_index_i;
          st_d   = ST_OK;
          vsel_d = V_ZERO;
        end
      end
      S_EXEC: begin
        i_d = '0;
        j_d = CW'(1);
        k_d = '0;
        case (cmd_q)
          CMD_APPEND: if (full) st_d = ST_OVER;
          CMD_INSERT: begin
            if (igt) st_d = ST_BADIDX;
            else if (full) st_d = ST_OVER;
            i_d  = dps_i.count;
            lo_d = CW'(idx_q);
          end
          CMD_GET: begin
            if (ibad) begin
              st_d   = ST_BADIDX;
              vsel_d = V_NEG1;
            end else begin
              vsel_d = V_ACC;
            end
          end
          CMD_EDIT:   if (ibad) st_d = ST_BADIDX;
          CMD_DELETE: begin
            if (ibad) st_d = ST_BADIDX;
            i_d = CW'(idx_q);
          end
          CMD_SWAP:   if (ibad || obad) st_d = ST_BADIDX;
          CMD_MAX, CMD_MIN, CMD_SUM: begin
            if (nz) st_d = ST_EMPTY;
            else vsel_d = V_ACC;
          end
          CMD_ROTATE: begin
            if (nz) st_d = ST_EMPTY;
            lo_d = '0;
          end
          CMD_DEDUPE: j_d = '0;
          default: ;
        endcase
      end
      S_ROT_LD:  i_d = dps_i.count - CW'(1);
      S_SHUP_WR: i_d = i_q - CW'(1);
      S_SHDN_WR: i_d = i_q + CW'(1);
      S_RED_AC:  i_d = i_q + CW'(1);
      S_SRT_CMP, S_SRT_WR2: begin
        if (state_q == S_SRT_WR2 || !dps_i.gt) begin
          if ((jw + CMPW'(1)) < nn) begin
            j_d = j_q + CW'(1);
          end else begin
            i_d = i_q + CW'(1);
            j_d = i_q + CW'(2);
          end
        end
      end
      S_SRT_END: begin
        if (cmd_q == CMD_SECOND) begin
          if (nlt2) st_d = ST_EMPTY;
          else vsel_d = V_ACC;
        end
      end
      S_DD_CMP: begin
        if (jlt && !dps_i.eq) begin
          j_d = j_q + CW'(1);
        end else begin
          i_d = i_q + CW'(1);
          j_d = '0;
          if (dd_wr) k_d = k_q + CW'(1);
        end
      end
      default: ;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    ctl_o         = '0;
    ctl_o.wsel    = W_DATA;
    ctl_o.acc_op  = A_HOLD;
    ctl_o.st      = st_q;
    ctl_o.vsel    = vsel_q;
    case (state_q)
      S_IDLE: ctl_o.lat = start;
      S_EXEC: begin
        ctl_o.fnd_clr = 1'b1;
        ctl_o.acc_op  = A_CLR;
        case (cmd_q)
          CMD_APPEND: begin
            if (!full) begin
              ctl_o.we      = 1'b1;
              ctl_o.waddr   = AW'(dps_i.count);
              ctl_o.cnt_we  = 1'b1;
              ctl_o.cnt_val = dps_i.count + CW'(1);
            end
          end
          CMD_GET:  ctl_o.raddr_a = AW'(idx_q);
          CMD_EDIT: begin
            ctl_o.we    = !ibad;
            ctl_o.waddr = AW'(idx_q);
          end
          CMD_DELETE: begin
            if (!ibad && !del_more) begin
              ctl_o.cnt_we  = 1'b1;
              ctl_o.cnt_val = dps_i.count - CW'(1);
            end
          end
          CMD_SWAP: begin
            ctl_o.raddr_a = AW'(idx_q);
            ctl_o.raddr_b = AW'(oidx_q);
          end
          CMD_ROTATE: ctl_o.raddr_a = AW'(dps_i.count - CW'(1));
          default: ;
        endcase
      end
      S_ROT_LD:  ctl_o.hold_ld = 1'b1;
      S_SHUP_RD: ctl_o.raddr_a = AW'(i_q - CW'(1));
      S_SHUP_WR: begin
        ctl_o.we    = 1'b1;
        ctl_o.waddr = AW'(i_q);
        ctl_o.wsel  = W_RDA;
      end
      S_PUT: begin
        ctl_o.we    = 1'b1;
        ctl_o.waddr = AW'(lo_q);
        ctl_o.wsel  = (cmd_q == CMD_ROTATE) ? W_HOLD : W_DATA;
        if (cmd_q == CMD_INSERT) begin
          ctl_o.cnt_we  = 1'b1;
          ctl_o.cnt_val = dps_i.count + CW'(1);
        end
      end
      S_SHDN_RD: ctl_o.raddr_a = AW'(i_q + CW'(1));
      S_SHDN_WR: begin
        ctl_o.we    = 1'b1;
        ctl_o.waddr = AW'(i_q);
        ctl_o.wsel  = W_RDA;
        if (!((iw + CMPW'(2)) < nn)) begin
          ctl_o.cnt_we  = 1'b1;
          ctl_o.cnt_val = dps_i.count - CW'(1);
        end
      end
      S_RD_WAIT: ctl_o.acc_op = A_LOAD;
      S_SWP_WR1: begin
        ctl_o.hold_ld = 1'b1;
        ctl_o.we      = 1'b1;
        ctl_o.waddr   = AW'(idx_q);
        ctl_o.wsel    = W_RDB;
      end
      S_SWP_WR2: begin
        ctl_o.we    = 1'b1;
        ctl_o.waddr = AW'(oidx_q);
        ctl_o.wsel  = W_HOLD;
      end
      S_SRT_RD, S_DD_RD: begin
        ctl_o.raddr_a = AW'(i_q);
        ctl_o.raddr_b = AW'(j_q);
      end
      S_SRT_CMP: begin
        ctl_o.hold_ld = dps_i.gt;
        ctl_o.we      = dps_i.gt;
        ctl_o.waddr   = AW'(i_q);
        ctl_o.wsel    = W_RDB;
      end
      S_SRT_WR2: begin
        ctl_o.we    = 1'b1;
        ctl_o.waddr = AW'(j_q);
        ctl_o.wsel  = W_HOLD;
      end
      S_SRT_END: ctl_o.raddr_a = AW'(dps_i.count - CW'(2));
      S_RED_RD:  ctl_o.raddr_a = AW'(i_q);
      S_RED_AC: begin
        case (cmd_q)
          CMD_SEARCH: ctl_o.fnd_set = 1'b1;
          CMD_MAX:    ctl_o.acc_op  = (i_q == '0) ? A_LOAD : A_MAX;
          CMD_MIN:    ctl_o.acc_op  = (i_q == '0) ? A_LOAD : A_MIN;
          CMD_SUM:    ctl_o.acc_op  = A_ADD;
          default: ;
        endcase
      end
      S_DD_CMP: begin
        ctl_o.we    = dd_wr;
        ctl_o.waddr = AW'(k_q);
        ctl_o.wsel  = W_RDA;
        // The last element of the pass fixes the new fill count.
        if (!(jlt && !dps_i.eq) && !((iw + CMPW'(1)) < nn)) begin
          ctl_o.cnt_we  = 1'b1;
          ctl_o.cnt_val = dd_wr ? (k_q + CW'(1)) : k_q;
        end
      end
      S_DONE: ctl_o.emit = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cap_q   <= 5'd16;
      cmd_q   <= CMD_STATUS;
      st_q    <= ST_OK;
      vsel_q  <= V_ZERO;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
      st_q    <= st_d;
      vsel_q  <= vsel_d;
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    oidx_q <= oidx_d;
    i_q    <= i_d;
    j_q    <= j_d;
    k_q    <= k_d;
    lo_q   <= lo_d;
  end

endmodule

// File: src/bounded_array_engine_core.sv
// One request at a time; the single-port-write store and its loop counter set the pace.
// A result shows for one cycle on result_valid_o and cannot be stalled.
// Asynchronous active-low reset empties the store and sets capacity to 16.
module bounded_array_engine_core import bae_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  command_i,
  input  logic [4:0]  index_i,
  input  logic [4:0]  other_index_i,
  input  logic [31:0] data_in_i,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_data_i,
  output logic [35:0] value_o,
  output logic        found_o,
  output logic [1:0]  status_o,
  output logic [4:0]  fill_count_o,
  output logic        result_valid_o
);

  ctl_t ctl;
  dps_t dps;

  bae_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .command_i     (command_i),
    .index_i       (index_i),
    .other_index_i (other_index_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .dps_i         (dps),
    .ctl_o         (ctl)
  );

  bae_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .data_in_i      (data_in_i),
    .ctl_i          (ctl),
    .dps_o          (dps),
    .value_o        (value_o),
    .found_o        (found_o),
    .status_o       (status_o),
    .fill_count_o   (fill_count_o),
    .result_valid_o (result_valid_o)
  );

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(dps.count) <= DEPTH) else $error("fill count above depth");
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("back-to-back results");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("request not taken");
  a_emit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.emit |=> !busy && result_valid_o) else $error("result without idle");
`endif

endmodule

// File: verif/bounded_array_engine_core_tb.sv
module bounded_array_engine_core_tb;
  import bae_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] CMD_UNUSED = 4'd15;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic [35:0] value;
    logic        found;
    logic [1:0]  status;
    logic [4:0]  fill_count;
  } array_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [3:0]  command_i = '0;
  logic [4:0]  index_i = '0;
  logic [4:0]  other_index_i = '0;
  logic [31:0] data_in_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [4:0]  cfg_data_i = '0;
  logic [35:0] value_o;
  logic        found_o;
  logic [1:0]  status_o;
  logic [4:0]  fill_count_o;
  logic        result_valid_o;

  // Shadow copy of the store, used to predict every result.
  logic signed [31:0] shadow_words [DEPTH];
  int                 shadow_count;
  logic [4:0]         shadow_capacity;
  array_result_t      pending_results [$];
  int                 fail_count = 0;
  int                 requests_sent = 0;
  int                 results_seen = 0;
  int                 idle_cycles = 0;

  bounded_array_engine_core DUT (
    .clk_i, .rst_ni, .start, .busy, .command_i, .index_i, .other_index_i,
    .data_in_i, .cfg_we_i, .cfg_data_i, .value_o, .found_o, .status_o,
    .fill_count_o, .result_valid_o
  );

  always #5 clk_i = ~clk_i;

  task automatic sort_shadow();
    logic signed [31:0] t;
    for (int i = 0; i < shadow_count; i++) begin
      for (int j = i + 1; j < shadow_count; j++) begin
        if (shadow_words[i] > shadow_words[j]) begin
          t = shadow_words[i];
          shadow_words[i] = shadow_words[j];
          shadow_words[j] = t;
        end
      end
    end
  endtask

  task automatic predict_array_op(input logic [3:0] cmd, input int idx, input int oidx,
                                  input logic signed [31:0] data);
    array_result_t      r;
    logic signed [35:0] acc;
    logic signed [31:0] t;
    int                 n;
    int                 cap;
    int                 kept;
    bit                 dup;
    r = '0;
    acc = '0;
    n = shadow_count;
    cap = (shadow_capacity < DEPTH) ? shadow_capacity : DEPTH;
    case (cmd)
      CMD_APPEND: begin
        if (n >= cap) r.status = ST_OVER;
        else begin
          shadow_words[n] = data;
          shadow_count = n + 1;
        end
      end
      CMD_INSERT: begin
        if (idx > n) r.status = ST_BADIDX;
        else if (n >= cap) r.status = ST_OVER;
        else begin
          for (int i = n; i > idx; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[idx] = data;
          shadow_count = n + 1;
        end
      end
      CMD_GET: begin
        if (idx >= n) begin
          r.status = ST_BADIDX;
          acc = -36'sd1;
        end else acc = 36'(shadow_words[idx]);
      end
      CMD_EDIT: begin
        if (idx >= n) r.status = ST_BADIDX;
        else shadow_words[idx] = data;
      end
      CMD_DELETE: begin
        if (idx >= n) r.status = ST_BADIDX;
        else begin
          for (int i = idx; i + 1 < n; i++) shadow_words[i] = shadow_words[i+1];
          shadow_count = n - 1;
        end
      end
      CMD_SWAP: begin
        if (idx >= n || oidx >= n) r.status = ST_BADIDX;
        else begin
          t = shadow_words[idx];
          shadow_words[idx] = shadow_words[oidx];
          shadow_words[oidx] = t;
        end
      end
      CMD_SORT: sort_shadow();
      CMD_MAX, CMD_MIN: begin
        if (n == 0) r.status = ST_EMPTY;
        else begin
          acc = 36'(shadow_words[0]);
          for (int i = 1; i < n; i++) begin
            if (cmd == CMD_MAX ? 36'(shadow_words[i]) > acc : 36'(shadow_words[i]) < acc)
              acc = 36'(shadow_words[i]);
          end
        end
      end
      CMD_SEARCH: begin
        for (int i = 0; i < n; i++) if (shadow_words[i] == data) r.found = 1'b1;
      end
      CMD_SUM: begin
        if (n == 0) r.status = ST_EMPTY;
        else for (int i = 0; i < n; i++) acc += 36'(shadow_words[i]);
      end
      CMD_ROTATE: begin
        if (n == 0) r.status = ST_EMPTY;
        else begin
          t = shadow_words[n-1];
          for (int i = n - 1; i > 0; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[0] = t;
        end
      end
      CMD_DEDUPE: begin
        kept = 0;
        for (int i = 0; i < n; i++) begin
          dup = 1'b0;
          for (int j = 0; j < kept; j++) if (shadow_words[j] == shadow_words[i]) dup = 1'b1;
          if (!dup) begin
            shadow_words[kept] = shadow_words[i];
            kept++;
          end
        end
        shadow_count = kept;
      end
      CMD_SECOND: begin
        sort_shadow();
        if (n < 2) r.status = ST_EMPTY;
        else acc = 36'(shadow_words[n-2]);
      end
      default: ;
    endcase
    r.value = acc;
    r.fill_count = 5'(shadow_count);
    pending_results.push_back(r);
  endtask

  // Sends one request after a random gap, or at once when no_gap is set, and predicts it once accepted.
  task automatic send_request(input logic [3:0] cmd, input logic [4:0] idx,
                              input logic [4:0] oidx, input logic [31:0] data,
                              input bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    command_i <= cmd;
    index_i <= idx;
    other_index_i <= oidx;
    data_in_i <= data;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    predict_array_op(cmd, idx, oidx, data);
    requests_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [4:0] cap);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_data_i <= cap;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    shadow_capacity = cap;
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($urandom);
      default: return 32'($signed($urandom_range(0, 12)) - 6);
    endcase
  endfunction

  task automatic test_empty_store();
    send_request(CMD_MAX, 0, 0, 0);
    send_request(CMD_MIN, 0, 0, 0);
    send_request(CMD_SUM, 0, 0, 0);
    send_request(CMD_ROTATE, 0, 0, 0);
    send_request(CMD_SECOND, 0, 0, 0);
    send_request(CMD_GET, 0, 0, 0);
    send_request(CMD_DELETE, 0, 0, 0);
    send_request(CMD_SEARCH, 0, 0, 32'd5);
    send_request(CMD_INSERT, 5'd1, 0, 32'd3);
    send_request(CMD_UNUSED, 5'd31, 5'd31, 32'hFFFF_FFFF);
  endtask

  task automatic test_basic_ops();
    send_request(CMD_APPEND, 0, 0, 32'h7FFF_FFFF);
    send_request(CMD_SECOND, 0, 0, 0);
    send_request(CMD_APPEND, 0, 0, 32'h8000_0000);
    send_request(CMD_INSERT, 5'd1, 0, 32'h7FFF_FFFF);
    send_request(CMD_INSERT, 5'd3, 0, 32'h0000_0001);
    send_request(CMD_SWAP, 5'd0, 5'd3, 0);
    send_request(CMD_SWAP, 5'd0, 5'd31, 0);
    send_request(CMD_EDIT, 5'd2, 0, 32'hFFFF_FFFF);
    send_request(CMD_GET, 5'd4, 0, 0);
    send_request(CMD_SUM, 0, 0, 0);
    send_request(CMD_DEDUPE, 0, 0, 0);
    send_request(CMD_SORT, 0, 0, 0);
    send_request(CMD_SEARCH, 0, 0, 32'h8000_0000);
    send_request(CMD_DELETE, 5'd3, 0, 0);
    send_request(CMD_STATUS, 0, 0, 0);
  endtask

  // Appends past a small capacity and past the depth, and then shrinks the capacity under the count.
  task automatic test_capacity_limits();
    write_capacity(5'd1);
    send_request(CMD_APPEND, 0, 0, 32'd9, 1);
    send_request(CMD_APPEND, 0, 0, 32'd9, 1);
    send_request(CMD_INSERT, 0, 0, 32'd9);
    write_capacity(5'd0);
    send_request(CMD_APPEND, 0, 0, 32'd1);
    write_capacity(5'd31);
    repeat (18) send_request(CMD_APPEND, 0, 0, pick_word());
    send_request(CMD_SUM, 0, 0, 0);
    send_request(CMD_SECOND, 0, 0, 0);
    write_capacity(5'd4);
    send_request(CMD_INSERT, 5'd2, 0, 32'd7);
    send_request(CMD_DEDUPE, 0, 0, 0);
  endtask

  task automatic test_random_mix(input int n_items);
    logic [4:0] caps [6] = '{5'd16, 5'd5, 5'd1, 5'd31, 5'd0, 5'd10};
    logic [3:0] cmd;
    bit         burst;
    for (int p = 0; p < 6; p++) begin
      write_capacity(caps[p]);
      for (int i = 0; i < n_items / 6; i++) begin
        // Fill more often while short, so shifts and sorts see full stores.
        if ($urandom_range(0, 99) < ((shadow_count < 6) ? 45 : 15)) cmd = CMD_APPEND;
        else cmd = 4'($urandom_range(0, 15));
        burst = ($urandom_range(0, 3) == 0);
        send_request(cmd, 5'($urandom_range(0, (shadow_count > 0 && $urandom_range(0, 3) != 0)
                                            ? shadow_count : 31)),
                     5'($urandom), ($urandom_range(0, 1) ? pick_word() : 32'($urandom)),
                     burst);
      end
    end
  endtask

  always @(posedge clk_i) begin
    array_result_t exp_r;
    if (result_valid_o) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (value_o !== exp_r.value) begin
          $error("value: expected %h, got %h", exp_r.value, value_o);
          fail_count++;
        end
        if (found_o !== exp_r.found) begin
          $error("found: expected %b, got %b", exp_r.found, found_o);
          fail_count++;
        end
        if (status_o !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, status_o);
          fail_count++;
        end
        if (fill_count_o !== exp_r.fill_count) begin
          $error("fill_count: expected %0d, got %0d", exp_r.fill_count, fill_count_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    shadow_count = 0;
    shadow_capacity = 5'd16;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_empty_store();
    test_basic_ops();
    test_capacity_limits();
    test_random_mix(660);
    wait_drained();
    repeat (20) @(negedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      fail_count++;
    end
    $display("Covered %0d requests over all commands and capacities 0 to 31; %0d results checked.",
             requests_sent, results_seen);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
